### design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/uart_pkg.sv
`timescale 1ns / 1ps

package uart_pkg;

  typedef logic [3:0]  phase_t;
  typedef logic [15:0] period_t;

  localparam phase_t  PH_IDLE       = 4'd0;
  localparam phase_t  PH_START      = 4'd1;
  localparam phase_t  PH_FIRST_DATA = 4'd2;
  localparam phase_t  PH_STOP       = 4'd10;

  localparam period_t PERIOD_RESET  = 16'd833;
  localparam period_t PERIOD_MIN    = 16'd2;

  typedef struct packed {
    logic line_out;
    logic send_ready;
  } tx_result_t;

  typedef struct packed {
    logic       got_valid;
    logic [7:0] got_byte;
  } rx_result_t;

  // Periods below two ticks behave as two.
  function automatic period_t eff_period(input period_t raw);
    eff_period = (raw < PERIOD_MIN) ? PERIOD_MIN : raw;
  endfunction

endpackage

### design/uart_tx_unit.sv
`timescale 1ns / 1ps

module uart_tx_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  uart_pkg::period_t   period,
  input  logic                send_valid,
  input  logic [7:0]          send_byte,
  output uart_pkg::tx_result_t result
);
  import uart_pkg::*;

  logic [7:0] send_shift, send_shift_next;
  phase_t     send_phase, send_phase_next;
  period_t    send_timer, send_timer_next;
  period_t    timer_inc;
  phase_t     bit_sel;
  logic       idle;

  assign idle      = (send_phase == PH_IDLE) || (send_phase > PH_STOP);
  assign timer_inc = send_timer + 16'd1;
  assign bit_sel   = send_phase - PH_FIRST_DATA;

  // Level driven from the state held before this beat's update.
  always_comb begin
    result.send_ready = idle;
    priority if (send_phase == PH_START) begin
      result.line_out = 1'b0;
    end else if (send_phase >= PH_FIRST_DATA && send_phase < PH_STOP) begin
      result.line_out = send_shift[bit_sel[2:0]];
    end else begin
      result.line_out = 1'b1;
    end
  end

  always_comb begin
    send_shift_next = send_shift;
    send_phase_next = send_phase;
    send_timer_next = send_timer;
    if (idle) begin
      send_phase_next = PH_IDLE;
      send_timer_next = '0;
      if (send_valid) begin
        send_shift_next = send_byte;
        send_phase_next = PH_START;
      end
    end else begin
      send_timer_next = timer_inc;
      if (timer_inc >= period) begin
        send_timer_next = '0;
        send_phase_next = (send_phase == PH_STOP) ? PH_IDLE : send_phase + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_shift <= '0;
      send_phase <= PH_IDLE;
      send_timer <= '0;
    end else if (step) begin
      send_shift <= send_shift_next;
      send_phase <= send_phase_next;
      send_timer <= send_timer_next;
    end
  end

endmodule

### design/uart_rx_unit.sv
`timescale 1ns / 1ps

module uart_rx_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  uart_pkg::period_t   period,
  input  logic                line_in,
  output uart_pkg::rx_result_t result
);
  import uart_pkg::*;

  logic [7:0] recv_shift, recv_shift_next;
  phase_t     recv_phase, recv_phase_next;
  period_t    recv_timer, recv_timer_next;
  period_t    timer_inc;
  period_t    half;
  logic       waiting;

  assign waiting   = (recv_phase == PH_IDLE) || (recv_phase > PH_STOP);
  assign timer_inc = recv_timer + 16'd1;
  assign half      = period >> 1;

  always_comb begin
    recv_shift_next = recv_shift;
    recv_phase_next = recv_phase;
    recv_timer_next = recv_timer;
    result.got_valid = 1'b0;
    result.got_byte  = '0;
    priority if (waiting) begin
      recv_timer_next = '0;
      recv_phase_next = line_in ? PH_IDLE : PH_START;
    end else if (recv_phase == PH_START) begin
      recv_timer_next = timer_inc;
      // mid start bit: confirm it is still low
      if (timer_inc >= half) begin
        recv_timer_next = '0;
        recv_phase_next = line_in ? PH_IDLE : PH_FIRST_DATA;
      end
    end else begin
      recv_timer_next = timer_inc;
      if (timer_inc >= period) begin
        recv_timer_next = '0;
        if (recv_phase < PH_STOP) begin
          recv_shift_next = {line_in, recv_shift[7:1]};
          recv_phase_next = recv_phase + 4'd1;
        end else begin
          result.got_valid = 1'b1;
          result.got_byte  = recv_shift;
          recv_phase_next  = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recv_shift <= '0;
      recv_phase <= PH_IDLE;
      recv_timer <= '0;
    end else if (step) begin
      recv_shift <= recv_shift_next;
      recv_phase <= recv_phase_next;
      recv_timer <= recv_timer_next;
    end
  end

endmodule

### design/uart_8n1_transceiver_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Width  Contents
// s_axis   in   16     one clock tick: send_valid, send_byte, line_in
// m_axis   out  16     one result per tick: line_out, send_ready, got_valid, got_byte
// cfg      in   16     bit_period write
//
// One beat per cycle sustained while m_axis is not stalled; each result is registered
// from its beat in the input register. Input register -> tx/rx update -> output register.
// Reset (rst, synchronous) empties both registers, idles tx and rx, bit_period = 833.
// A stall on m_axis holds the output register; the input register still takes one
// more beat, then s_axis_tready drops until the output drains.
`include "assert_macros.svh"

module uart_8n1_transceiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] send_valid, [8:1] send_byte, [9] line_in, rest 0
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] line_out, [1] send_ready, [2] got_valid,
                                      // [10:3] got_byte, rest 0
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import uart_pkg::*;

  period_t    bit_period;
  period_t    period;
  logic       in_v;
  logic       in_send_valid;
  logic [7:0] in_send_byte;
  logic       in_line;
  logic       out_v;
  logic [15:0] out_data;
  logic       advance;
  tx_result_t tx_res;
  rx_result_t rx_res;

  assign cfg_ready     = 1'b1;
  assign period        = eff_period(bit_period);
  assign advance       = in_v && (!out_v || m_axis_tready);
  assign s_axis_tready = !in_v || advance;
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bit_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tready) begin
      in_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_send_valid <= s_axis_tdata[0];
      in_send_byte  <= s_axis_tdata[8:1];
      in_line       <= s_axis_tdata[9];
    end
  end

  uart_tx_unit u_tx (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .period    (period),
    .send_valid(in_send_valid),
    .send_byte (in_send_byte),
    .result    (tx_res)
  );

  uart_rx_unit u_rx (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .period (period),
    .line_in(in_line),
    .result (rx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {5'd0, rx_res.got_byte, rx_res.got_valid,
                   tx_res.send_ready, tx_res.line_out};
    end
  end

  `ASSERT_SAME(a_stall_only_when_full, clk, rst, !s_axis_tready,
               in_v && out_v && !m_axis_tready)
  `ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_v)
  `ASSERT_SAME(a_idle_line_high, clk, rst, m_axis_tvalid && m_axis_tdata[1],
               m_axis_tdata[0])
  `ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !in_v && !out_v)

endmodule

### tb/tb_uart_8n1_transceiver_core.sv
`timescale 1ns / 1ps

module tb_uart_8n1_transceiver_core;
  import uart_pkg::*;

  // one clock tick offered to the block, packed as in s_axis_tdata[9:0]
  typedef struct packed {
    logic       line_in;
    logic [7:0] send_byte;
    logic       send_valid;
  } tick_in_t;

  // one result beat, packed as in m_axis_tdata[10:0]
  typedef struct packed {
    logic [7:0] got_byte;
    logic       got_valid;
    logic       send_ready;
    logic       line_out;
  } tick_result_t;

  typedef enum logic [0:0] {ROW_TICK, ROW_PERIOD} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    period_t      period;
    tick_in_t     stim;
    logic         has_exp;
    tick_result_t exp;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // shadow state of the transceiver
  period_t    cur_period;
  logic [7:0] tx_shift;
  phase_t     tx_phase;
  period_t    tx_timer;
  logic [7:0] rx_shift;
  phase_t     rx_phase;
  period_t    rx_timer;

  tick_result_t expected_results[$];
  logic         line_plan[$];
  dir_row_t     directed_rows[$];

  int fail_count = 0;
  int ticks_sent = 0;
  int tx_bytes_taken = 0;
  int rx_bytes_seen = 0;
  int burst_left = 0;
  int stall_cycle = 0;

  period_t bit_periods[] = '{16'd2, 16'd3, 16'd0, 16'd5, 16'd1, 16'd7, 16'd16,
                             16'd65535, 16'd4, 16'd2};

  uart_8n1_transceiver_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: long ready stretches, coin flips, mostly-ready and mostly-stalled
  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[8:7])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= (stall_cycle[1:0] != 2'd0);
      default: m_axis_tready <= (stall_cycle[2:0] == 3'd0);
    endcase
  end

  // Advance the shadow transceiver by one tick, return what the block must report.
  function automatic tick_result_t predict_tick(input tick_in_t b);
    period_t      p;
    period_t      half;
    logic         tx_idle;
    tick_result_t r;
    p = (cur_period < PERIOD_MIN) ? PERIOD_MIN : cur_period;
    half = p >> 1;
    tx_idle = (tx_phase == PH_IDLE) || (tx_phase > PH_STOP);
    r = '0;
    // line level and ready reflect the state before this tick
    if (tx_phase == PH_START)
      r.line_out = 1'b0;
    else if (tx_phase >= PH_FIRST_DATA && tx_phase < PH_STOP)
      r.line_out = tx_shift[3'(tx_phase - PH_FIRST_DATA)];
    else
      r.line_out = 1'b1;
    r.send_ready = tx_idle;

    if (tx_idle) begin
      tx_phase = PH_IDLE;
      tx_timer = '0;
      if (b.send_valid) begin
        tx_shift = b.send_byte;
        tx_phase = PH_START;
        tx_bytes_taken++;
      end
    end else begin
      tx_timer = tx_timer + 16'd1;
      if (tx_timer >= p) begin
        tx_timer = '0;
        tx_phase = tx_phase + 4'd1;
        if (tx_phase > PH_STOP)
          tx_phase = PH_IDLE;
      end
    end

    if (rx_phase == PH_IDLE || rx_phase > PH_STOP) begin
      rx_phase = b.line_in ? PH_IDLE : PH_START;
      rx_timer = '0;
    end else if (rx_phase == PH_START) begin
      rx_timer = rx_timer + 16'd1;
      if (rx_timer >= half) begin
        rx_timer = '0;
        rx_phase = b.line_in ? PH_IDLE : PH_FIRST_DATA;
      end
    end else begin
      rx_timer = rx_timer + 16'd1;
      if (rx_timer >= p) begin
        rx_timer = '0;
        if (rx_phase < PH_STOP) begin
          rx_shift = {b.line_in, rx_shift[7:1]};
          rx_phase = rx_phase + 4'd1;
        end else begin
          // stop bit level is not checked
          r.got_valid = 1'b1;
          r.got_byte = rx_shift;
          rx_phase = PH_IDLE;
        end
      end
    end
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic sv, input logic [7:0] sb, input logic li);
    dir_row_t row;
    row.kind = ROW_TICK;
    row.period = '0;
    row.stim = '{line_in: li, send_byte: sb, send_valid: sv};
    row.has_exp = 1'b0;
    row.exp = '0;
    return row;
  endfunction

  function automatic dir_row_t checked_row(input logic sv, input logic [7:0] sb, input logic li,
                                           input logic lo, input logic rdy);
    dir_row_t row;
    row = tick_row(sv, sb, li);
    row.has_exp = 1'b1;
    row.exp = '{got_byte: 8'h00, got_valid: 1'b0, send_ready: rdy, line_out: lo};
    return row;
  endfunction

  function automatic dir_row_t period_row(input period_t value);
    dir_row_t row;
    row = tick_row(1'b0, 8'h00, 1'b1);
    row.kind = ROW_PERIOD;
    row.period = value;
    return row;
  endfunction

  function automatic tick_in_t random_tick(input logic li);
    tick_in_t b;
    b.send_valid = ($urandom_range(0, 3) == 0);
    b.send_byte = 8'($urandom_range(0, 255));
    b.line_in = li;
    return b;
  endfunction

  // Offer one tick; entered and left at a falling edge.
  task automatic send_tick(input tick_in_t b, input logic typed, input tick_result_t typed_res);
    int           gap;
    tick_result_t want;
    if ($urandom_range(0, 299) == 0) begin
      s_axis_tvalid <= 1'b0;
      wait (expected_results.size() == 0);
      @(negedge clk);
    end
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, b};
    do @(posedge clk); while (!s_axis_tready);
    want = predict_tick(b);
    if (typed)
      want = typed_res;
    expected_results.push_back(want);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Register write with the datapath drained.
  task automatic write_bit_period(input period_t value);
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cur_period = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Queue line levels for one serial frame at the current period, well formed or not.
  task automatic plan_serial_frame();
    int         p;
    int         half;
    int         shape;
    int         bit_len;
    logic [7:0] payload;
    p = int'((cur_period < PERIOD_MIN) ? PERIOD_MIN : cur_period);
    half = p / 2;
    shape = $urandom_range(0, 9);
    payload = 8'($urandom_range(0, 255));
    bit_len = p;
    repeat ($urandom_range(0, 2 * p)) line_plan.push_back(1'b1);
    if (shape == 0) begin
      // low pulse gone before mid start bit
      repeat ($urandom_range(1, half)) line_plan.push_back(1'b0);
      repeat (p) line_plan.push_back(1'b1);
    end else if (shape == 1) begin
      repeat ($urandom_range(1, 4 * p)) line_plan.push_back(1'($urandom_range(0, 1)));
      repeat (2 * p) line_plan.push_back(1'b1);
    end else begin
      if (shape == 2 && p > 3)
        bit_len = ($urandom_range(0, 1) == 1) ? p + 1 : p - 1;
      repeat (bit_len) line_plan.push_back(1'b0);
      for (int i = 0; i < 8; i++)
        repeat (bit_len) line_plan.push_back(payload[i]);
      if (shape == 3) begin
        // low stop bit, sometimes held low into a new start
        repeat (bit_len + $urandom_range(0, 2 * p)) line_plan.push_back(1'b0);
        repeat (p) line_plan.push_back(1'b1);
      end else begin
        repeat (bit_len) line_plan.push_back(1'b1);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    tick_result_t want;
    tick_result_t seen;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[10:0];
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (seen.line_out !== want.line_out) begin
          $error("line_out: expected %0b, got %0b", want.line_out, seen.line_out);
          fail_count++;
        end
        if (seen.send_ready !== want.send_ready) begin
          $error("send_ready: expected %0b, got %0b", want.send_ready, seen.send_ready);
          fail_count++;
        end
        if (seen.got_valid !== want.got_valid) begin
          $error("got_valid: expected %0b, got %0b", want.got_valid, seen.got_valid);
          fail_count++;
        end
        if (seen.got_byte !== want.got_byte) begin
          $error("got_byte: expected %h, got %h", want.got_byte, seen.got_byte);
          fail_count++;
        end
        if (want.got_valid)
          rx_bytes_seen++;
      end
    end
  end

  initial begin
    cur_period = PERIOD_RESET;
    tx_shift = '0;
    tx_phase = PH_IDLE;
    tx_timer = '0;
    rx_shift = '0;
    rx_phase = PH_IDLE;
    rx_timer = '0;

    // at reset period: idle outputs, byte taken, offer while busy dropped
    directed_rows.push_back(checked_row(1'b0, 8'h00, 1'b1, 1'b1, 1'b1));
    directed_rows.push_back(checked_row(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1));
    directed_rows.push_back(checked_row(1'b1, 8'h00, 1'b1, 1'b0, 1'b0));
    // shortest period while the start bit is under way
    directed_rows.push_back(period_row(PERIOD_MIN));
    // false start
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    // frame carrying 8'hA5, two ticks per bit
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 8'h00, 1'b1));
    directed_rows.push_back(tick_row(1'b1, 8'h5A, 1'b1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_PERIOD)
        write_bit_period(directed_rows[i].period);
      else
        send_tick(directed_rows[i].stim, directed_rows[i].has_exp, directed_rows[i].exp);
    end

    foreach (bit_periods[k]) begin
      write_bit_period(bit_periods[k]);
      if (bit_periods[k] == 16'hFFFF) begin
        // frames too long to finish; just watch the line hold
        repeat (40) send_tick(random_tick(1'($urandom_range(0, 1))), 1'b0, '0);
      end else begin
        plan_serial_frame();
        while (line_plan.size() > 0)
          send_tick(random_tick(line_plan.pop_front()), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk);

    $display("%0d ticks over %0d bit period settings (0 and 1 through 65535);",
             ticks_sent, bit_periods.size() + 1);
    $display("transmitter took %0d bytes, receiver reported %0d frames.",
             tx_bytes_taken, rx_bytes_seen);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/uart_pkg.sv
design/uart_tx_unit.sv
design/uart_rx_unit.sv
design/uart_8n1_transceiver_core.sv
tb/tb_uart_8n1_transceiver_core.sv
